// ----- design/fuzzy_pendulum_controller_unit_macros.svh -----
// Assertion macros shared by the checker of the fuzzy pendulum controller.
// Depends on nothing; included by design/fpc_checker.sv.
`ifndef FUZZY_PENDULUM_CONTROLLER_UNIT_MACROS_SVH
`define FUZZY_PENDULUM_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FPC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FPC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/fpc_pkg.sv -----
// Package of the fuzzy pendulum controller: types, membership shapes, rule ROM.
// No dependencies; used by fuzzy_pendulum_controller_unit.
`default_nettype none

package fpc_pkg;

    typedef enum logic [1:0] {
        MF_LEFT,
        MF_REG,
        MF_RIGHT
    } mf_kind_t;

    typedef enum logic [1:0] {
        V_POS,
        V_VEL,
        V_ANG,
        V_RATE
    } fz_var_t;

    typedef enum logic [2:0] {
        S_NL,
        S_NS,
        S_ZE,
        S_PS,
        S_PL
    } fz_set_t;

    typedef enum logic [3:0] {
        O_NVL,
        O_NL,
        O_NM,
        O_NS,
        O_ZE,
        O_PS,
        O_PM,
        O_PL,
        O_PVL
    } fz_out_t;

    typedef enum logic [2:0] {
        MAG_ZERO,
        MAG_SMALL,
        MAG_MEDIUM,
        MAG_LARGE,
        MAG_VLARGE
    } mag_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RULE,
        ST_FLUSH,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } fpc_state_t;

    // breakpoints in half input units
    typedef struct packed {
        mf_kind_t          kind;
        logic signed [3:0] a;
        logic signed [3:0] b;
        logic signed [3:0] c;
        logic signed [3:0] d;
    } mf_shape_t;

    typedef struct packed {
        fz_var_t var0;
        fz_set_t set0;
        fz_var_t var1;
        fz_set_t set1;
        fz_out_t out_code;
    } fz_rule_t;

    localparam int RULE_COUNT = 26;
    localparam int RULE_IDX_W = 5;
    localparam int MAG_W      = 7;
    localparam int FORCE_W    = 16;

    localparam logic [2:0] CFG_OUT_SMALL      = 3'd0;
    localparam logic [2:0] CFG_OUT_MEDIUM     = 3'd1;
    localparam logic [2:0] CFG_OUT_LARGE      = 3'd2;
    localparam logic [2:0] CFG_OUT_VERY_LARGE = 3'd3;

    localparam logic [MAG_W-1:0] RST_SMALL      = 7'd30;
    localparam logic [MAG_W-1:0] RST_MEDIUM     = 7'd60;
    localparam logic [MAG_W-1:0] RST_LARGE      = 7'd85;
    localparam logic [MAG_W-1:0] RST_VERY_LARGE = 7'd95;

    localparam logic [FORCE_W-1:0] FORCE_MAX = 16'h7FFF;
    localparam logic [FORCE_W-1:0] FORCE_MIN = 16'h8000;

    function automatic mf_shape_t mk_shape(input mf_kind_t k, input int a, input int b,
                                           input int c, input int d);
        mf_shape_t s;
        s.kind = k;
        s.a    = 4'(a);
        s.b    = 4'(b);
        s.c    = 4'(c);
        s.d    = 4'(d);
        return s;
    endfunction

    function automatic fz_rule_t mk_rule(input fz_var_t v0, input fz_set_t s0,
                                         input fz_var_t v1, input fz_set_t s1,
                                         input fz_out_t o);
        fz_rule_t r;
        r.var0     = v0;
        r.set0     = s0;
        r.var1     = v1;
        r.set1     = s1;
        r.out_code = o;
        return r;
    endfunction

    localparam mf_shape_t SHAPES [4][5] = '{
        '{mk_shape(MF_LEFT, -6, -6, -6, -4), mk_shape(MF_REG, -6, -4, -4, -2),
          mk_shape(MF_REG, -4, -2, 2, 4), mk_shape(MF_REG, 2, 4, 4, 6),
          mk_shape(MF_RIGHT, 4, 6, 6, 6)},
        '{mk_shape(MF_LEFT, -6, -6, -6, -4), mk_shape(MF_REG, -6, -4, -4, -2),
          mk_shape(MF_REG, -4, -2, 2, 4), mk_shape(MF_REG, 2, 4, 4, 6),
          mk_shape(MF_RIGHT, 4, 6, 6, 6)},
        '{mk_shape(MF_LEFT, -5, -5, -5, -3), mk_shape(MF_REG, -5, -3, -3, -1),
          mk_shape(MF_REG, -3, -1, 1, 3), mk_shape(MF_REG, 1, 3, 3, 5),
          mk_shape(MF_RIGHT, 3, 5, 5, 5)},
        '{mk_shape(MF_LEFT, -4, -4, -4, -2), mk_shape(MF_REG, -4, -2, -2, 0),
          mk_shape(MF_REG, -2, 0, 0, 2), mk_shape(MF_REG, 0, 2, 2, 4),
          mk_shape(MF_RIGHT, 2, 4, 4, 4)}
    };

    localparam fz_rule_t RULE_ROM [RULE_COUNT] = '{
        mk_rule(V_ANG, S_NL, V_RATE, S_NL, O_PL), mk_rule(V_ANG, S_NL, V_RATE, S_NS, O_PM),
        mk_rule(V_ANG, S_NL, V_RATE, S_ZE, O_PS), mk_rule(V_ANG, S_NS, V_RATE, S_NL, O_PM),
        mk_rule(V_ANG, S_NS, V_RATE, S_NS, O_PS), mk_rule(V_ANG, S_NS, V_RATE, S_ZE, O_ZE),
        mk_rule(V_ANG, S_ZE, V_RATE, S_NL, O_NS), mk_rule(V_ANG, S_ZE, V_RATE, S_NS, O_NM),
        mk_rule(V_ANG, S_ZE, V_RATE, S_ZE, O_ZE), mk_rule(V_ANG, S_PS, V_RATE, S_NS, O_NM),
        mk_rule(V_ANG, S_PS, V_RATE, S_ZE, O_NS), mk_rule(V_ANG, S_PL, V_RATE, S_NS, O_PS),
        mk_rule(V_ANG, S_PL, V_RATE, S_ZE, O_PL),
        mk_rule(V_POS, S_NL, V_VEL, S_NL, O_PVL), mk_rule(V_POS, S_NL, V_VEL, S_NS, O_PL),
        mk_rule(V_POS, S_NL, V_VEL, S_ZE, O_PM), mk_rule(V_POS, S_NS, V_VEL, S_NL, O_PM),
        mk_rule(V_POS, S_NS, V_VEL, S_NS, O_PS), mk_rule(V_POS, S_NS, V_VEL, S_ZE, O_ZE),
        mk_rule(V_POS, S_ZE, V_VEL, S_NL, O_NS), mk_rule(V_POS, S_ZE, V_VEL, S_NS, O_NM),
        mk_rule(V_POS, S_ZE, V_VEL, S_ZE, O_ZE), mk_rule(V_POS, S_PS, V_VEL, S_NS, O_NM),
        mk_rule(V_POS, S_PS, V_VEL, S_ZE, O_NS), mk_rule(V_POS, S_PL, V_VEL, S_NS, O_PS),
        mk_rule(V_POS, S_PL, V_VEL, S_ZE, O_PL)
    };

endpackage

`default_nettype wire

// ----- design/fpc_divider.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Standalone; instantiated by fuzzy_pendulum_controller_unit.
`default_nettype none

module fpc_divider #(
    parameter int DW = 17,
    parameter int QW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] low_bits,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg,  rem_next;
    logic [QW-1:0] low_reg,  low_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, low_reg[QW-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            low_next  = low_bits;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            low_next  = {low_reg[QW-2:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- design/fuzzy_pendulum_controller_unit.sv -----
// Fuzzy cart-and-pole controller: rule walk, weighted sum and serial divide.
// Depends on fpc_pkg and fpc_divider.
//
// Usage:
//  - Input channel (in_valid/in_stall) carries one beat of four Q4.12 samples.
//    in_stall is high while an item is being worked on.
//  - Output channel (out_valid/out_stall) carries drive_force (Q8.8) and
//    no_rule_fired. Results sit in an output register; a new item is taken
//    while the previous result still waits on out_stall.
//  - From an input beat, the item passes ST_RULE, ST_FLUSH, ST_SETUP,
//    ST_DIV and ST_OUT before out_valid; ST_DIV is skipped when no rule
//    fires. The next item is taken only once the block is back in ST_IDLE.
//  - The 26 rules pass through one membership/min unit and one multiplier,
//    one rule a cycle; the quotient comes from a bit-serial divider,
//    one bit a cycle.
//  - A stalled output holds its beat; the block waits with the next result
//    until the output register frees.
//  - cfg_write/cfg_index/cfg_data set the four singleton magnitudes; write
//    only while idle. Reset restores 30/60/85/95 and empties the output.
`default_nettype none

module fuzzy_pendulum_controller_unit #(
    parameter int INPUT_FRAC_BITS  = 12,
    parameter int OUTPUT_FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  cart_position,
    input  logic signed [15:0]  cart_velocity,
    input  logic signed [15:0]  pole_angle,
    input  logic signed [15:0]  pole_rate,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  drive_force,
    output logic                no_rule_fired
);

    localparam int IFB = INPUT_FRAC_BITS;
    localparam int OFB = OUTPUT_FRAC_BITS;
    localparam int XW  = (IFB + 3 > 16) ? IFB + 3 : 16;
    localparam int WW  = IFB + 1;
    localparam int PW  = WW + fpc_pkg::MAG_W;
    localparam int DW  = IFB + 5;
    localparam int NW  = IFB + 13;
    localparam int QW  = OFB + 7;
    localparam int SW  = (QW + 1 > 17) ? QW + 1 : 17;
    localparam int RW  = fpc_pkg::RULE_IDX_W;
    localparam int FW  = fpc_pkg::FORCE_W;

    localparam logic [WW-1:0] ONE = {1'b1, {IFB{1'b0}}};

    function automatic logic signed [XW-1:0] bpt(input logic signed [3:0] v);
        logic signed [XW-1:0] e;
        e = $signed({{(XW-4){v[3]}}, v});
        return e <<< (IFB - 1);
    endfunction

    function automatic logic [WW-1:0] degree(input logic signed [XW-1:0] x,
                                             input fpc_pkg::mf_shape_t s);
        logic signed [XW-1:0] a;
        logic signed [XW-1:0] b;
        logic signed [XW-1:0] c;
        logic signed [XW-1:0] d;
        logic signed [XW-1:0] up;
        logic signed [XW-1:0] dn;
        logic [WW-1:0]        r;
        a  = bpt(s.a);
        b  = bpt(s.b);
        c  = bpt(s.c);
        d  = bpt(s.d);
        up = x - a;
        dn = d - x;
        r  = '0;
        case (s.kind)
            fpc_pkg::MF_LEFT:
            begin
                if (x <= c)
                    r = ONE;
                else if (x < d)
                    r = dn[WW-1:0];
            end
            fpc_pkg::MF_RIGHT:
            begin
                if (x >= b)
                    r = ONE;
                else if (x > a)
                    r = up[WW-1:0];
            end
            fpc_pkg::MF_REG:
            begin
                if (x <= a || x >= d)
                    r = '0;
                else if (x >= b && x <= c)
                    r = ONE;
                else if (x < b)
                    r = up[WW-1:0];
                else
                    r = dn[WW-1:0];
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // singleton magnitudes
    logic [6:0] small_reg, medium_reg, large_reg, vlarge_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_reg  <= fpc_pkg::RST_SMALL;
            medium_reg <= fpc_pkg::RST_MEDIUM;
            large_reg  <= fpc_pkg::RST_LARGE;
            vlarge_reg <= fpc_pkg::RST_VERY_LARGE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fpc_pkg::CFG_OUT_SMALL:      small_reg  <= cfg_data;
                fpc_pkg::CFG_OUT_MEDIUM:     medium_reg <= cfg_data;
                fpc_pkg::CFG_OUT_LARGE:      large_reg  <= cfg_data;
                fpc_pkg::CFG_OUT_VERY_LARGE: vlarge_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fpc_pkg::fpc_state_t state_reg, state_next;

    logic [RW-1:0]        idx_reg, idx_next;
    logic signed [XW-1:0] pos_reg, vel_reg, ang_reg, rate_reg;
    logic [WW-1:0]        w_reg, w_next;
    logic [6:0]           mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 pend_reg, pend_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic [DW-1:0]        den_reg, den_next;
    logic                 sign_reg, sign_next;
    logic [FW-1:0]        res_force_reg, res_force_next;
    logic                 res_flag_reg, res_flag_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FW-1:0]        force_reg, force_next;
    logic                 flag_reg, flag_next;

    fpc_pkg::fz_rule_t    rule;
    logic signed [XW-1:0] x0, x1;
    logic [WW-1:0]        m0, m1, w_min;
    logic [3:0]           code;
    fpc_pkg::mag_sel_t    msel;
    logic [6:0]           mag_sel_val;
    logic [PW-1:0]        prod;
    logic signed [NW-1:0] prod_s;
    logic signed [NW-1:0] num_abs_s;
    logic [NW-2:0]        num_abs;
    logic                 accept;
    logic                 div_start;
    logic                 div_done;
    logic [QW-1:0]        div_quot;
    logic [SW-1:0]        q_ext;
    logic [FW-1:0]        q_neg;

    // rule evaluation
    always_comb
    begin
        rule = fpc_pkg::RULE_ROM[idx_reg];
        case (rule.var0)
            fpc_pkg::V_POS:  x0 = pos_reg;
            fpc_pkg::V_VEL:  x0 = vel_reg;
            fpc_pkg::V_ANG:  x0 = ang_reg;
            fpc_pkg::V_RATE: x0 = rate_reg;
            default:         x0 = pos_reg;
        endcase
        case (rule.var1)
            fpc_pkg::V_POS:  x1 = pos_reg;
            fpc_pkg::V_VEL:  x1 = vel_reg;
            fpc_pkg::V_ANG:  x1 = ang_reg;
            fpc_pkg::V_RATE: x1 = rate_reg;
            default:         x1 = pos_reg;
        endcase
        m0    = degree(x0, fpc_pkg::SHAPES[rule.var0][rule.set0]);
        m1    = degree(x1, fpc_pkg::SHAPES[rule.var1][rule.set1]);
        w_min = (m0 < m1) ? m0 : m1;
        code  = rule.out_code;
        if (code >= 4'(fpc_pkg::O_ZE))
            msel = fpc_pkg::mag_sel_t'(3'(code - 4'(fpc_pkg::O_ZE)));
        else
            msel = fpc_pkg::mag_sel_t'(3'(4'(fpc_pkg::O_ZE) - code));
        case (msel)
            fpc_pkg::MAG_SMALL:  mag_sel_val = small_reg;
            fpc_pkg::MAG_MEDIUM: mag_sel_val = medium_reg;
            fpc_pkg::MAG_LARGE:  mag_sel_val = large_reg;
            fpc_pkg::MAG_VLARGE: mag_sel_val = vlarge_reg;
            default:             mag_sel_val = '0;
        endcase
    end

    always_comb
    begin
        prod      = PW'(w_reg) * PW'(mag_reg);
        prod_s    = $signed(NW'(prod));
        num_abs_s = num_reg[NW-1] ? -num_reg : num_reg;
        num_abs   = num_abs_s[NW-2:0];
        q_ext     = SW'(div_quot);
        q_neg     = ~q_ext[FW-1:0] + FW'(1);
    end

    assign accept = in_valid && (state_reg == fpc_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        pend_next      = 1'b0;
        num_next       = num_reg;
        den_next       = den_reg;
        sign_next      = sign_reg;
        res_force_next = res_force_reg;
        res_flag_next  = res_flag_reg;
        force_next     = force_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;

        if (pend_reg)
        begin
            num_next = neg_reg ? num_reg - prod_s : num_reg + prod_s;
            den_next = den_reg + DW'(w_reg);
        end

        case (state_reg)
            fpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    num_next   = '0;
                    den_next   = '0;
                    state_next = fpc_pkg::ST_RULE;
                end
            end
            fpc_pkg::ST_RULE:
            begin
                w_next    = w_min;
                mag_next  = mag_sel_val;
                neg_next  = code < 4'(fpc_pkg::O_ZE);
                pend_next = 1'b1;
                idx_next  = idx_reg + RW'(1);
                if (idx_reg == RW'(fpc_pkg::RULE_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = fpc_pkg::ST_FLUSH;
                end
            end
            fpc_pkg::ST_FLUSH:
            begin
                state_next = fpc_pkg::ST_SETUP;
            end
            fpc_pkg::ST_SETUP:
            begin
                if (den_reg == '0)
                begin
                    res_force_next = '0;
                    res_flag_next  = 1'b1;
                    state_next     = fpc_pkg::ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    sign_next  = num_reg[NW-1];
                    state_next = fpc_pkg::ST_DIV;
                end
            end
            fpc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_flag_next = 1'b0;
                    if (!sign_reg)
                        res_force_next = (q_ext > SW'(32767)) ? fpc_pkg::FORCE_MAX
                                                              : q_ext[FW-1:0];
                    else
                        res_force_next = (q_ext > SW'(32768)) ? fpc_pkg::FORCE_MIN : q_neg;
                    state_next = fpc_pkg::ST_OUT;
                end
            end
            fpc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    force_next     = res_force_reg;
                    flag_next      = res_flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = fpc_pkg::ST_IDLE;
                end
            end
            default: state_next = fpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg  <= XW'(cart_position);
            vel_reg  <= XW'(cart_velocity);
            ang_reg  <= XW'(pole_angle);
            rate_reg <= XW'(pole_rate);
        end
        w_reg         <= w_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        sign_reg      <= sign_next;
        res_force_reg <= res_force_next;
        res_flag_reg  <= res_flag_next;
        force_reg     <= force_next;
        flag_reg      <= flag_next;
    end

    fpc_divider #(
        .DW (DW),
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (num_abs[NW-2:7]),
        .low_bits ({num_abs[6:0], {OFB{1'b0}}}),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_stall      = (state_reg != fpc_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign drive_force   = $signed(force_reg);
    assign no_rule_fired = flag_reg;

endmodule

`default_nettype wire

// ----- design/fpc_checker.sv -----
// Port-level checker for fuzzy_pendulum_controller_unit, bound to the top level.
// Depends on fuzzy_pendulum_controller_unit_macros.svh.
`default_nettype none
`include "fuzzy_pendulum_controller_unit_macros.svh"

module fpc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] drive_force,
    input logic               no_rule_fired
);

    `FPC_ASSERT_IMP(a_zero_force, clk, rst_n, out_valid && no_rule_fired, drive_force == 16'sd0, "no rule fired but drive_force nonzero")
    `FPC_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accepting a beat")
    `FPC_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared right after input beat")
    `FPC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(drive_force) && $stable(no_rule_fired), "stalled output beat changed")

endmodule

bind fuzzy_pendulum_controller_unit fpc_checker u_fpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_force   (drive_force),
    .no_rule_fired (no_rule_fired)
);

`default_nettype wire
